// ----- design/cfr_pkg.sv -----
// ----------------------------------------------------------------------------
// cfr_pkg
// Types and constants shared by the command frame receiver modules.
// ----------------------------------------------------------------------------
package cfr_pkg;

    localparam int PAYLOAD_BYTES = 12;
    localparam int IDX_W         = 4;
    localparam int TDATA_OUT_W   = 112;
    localparam logic [31:0] TIMEOUT_RESET = 32'd10000;

    localparam logic [7:0] FRAME_SOF      = 8'h7E;
    localparam logic [7:0] CMD_CONNECT    = 8'h01;
    localparam logic [7:0] CMD_START      = 8'h02;
    localparam logic [7:0] CMD_STOP       = 8'h04;
    localparam logic [7:0] CMD_PING       = 8'h10;
    localparam logic [7:0] CMD_GAINS_MAIN = 8'h20;
    localparam logic [7:0] CMD_GAINS_YAW  = 8'h40;

    typedef enum logic [1:0] {
        EV_CONNECT = 2'd0,
        EV_ACK     = 2'd1,
        EV_TIMEOUT = 2'd2
    } t_event;

    typedef enum logic [3:0] {
        PH_HUNT = 4'b0001,
        PH_CMD  = 4'b0010,
        PH_DATA = 4'b0100,
        PH_SUM  = 4'b1000
    } t_phase;

    typedef struct packed {
        logic        mode;
        logic [7:0]  rx_byte;
    } t_item;

    typedef struct packed {
        t_event      event_res;
        logic [7:0]  command;
        logic        success;
        logic        gains_valid;
        logic [31:0] gain_word_p;
        logic [31:0] gain_word_i;
        logic [31:0] gain_word_d;
        logic        streaming_active;
    } t_result;

endpackage

// ----- design/cfr_in_reg.sv -----
// ----------------------------------------------------------------------------
// cfr_in_reg
// Input register: holds one accepted beat until the core consumes it.
// ----------------------------------------------------------------------------
module cfr_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  cfr_pkg::t_item i_item,
    output logic           o_valid,
    output cfr_pkg::t_item o_item,
    input  logic           i_take
);
    import cfr_pkg::*;

    logic  r_valid;
    t_item r_item;

    // A new beat may enter when the register is empty or is drained this cycle.
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ----- design/cfr_core.sv -----
// ----------------------------------------------------------------------------
// cfr_core
// Frame parser, checksum, payload store and watchdog; one item per cycle unless a result waits for the output register.
// ----------------------------------------------------------------------------
module cfr_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic [31:0]      i_cfg_data,
    input  logic             i_valid,
    input  cfr_pkg::t_item   i_item,
    output logic             o_take,
    input  logic             i_out_ready,
    output logic             o_push,
    output cfr_pkg::t_result o_result
);
    import cfr_pkg::*;

    t_phase              r_phase,   n_phase;
    logic [7:0]          r_cmd,     n_cmd;
    logic [IDX_W-1:0]    r_idx,     n_idx;
    logic [15:0]         r_sum,     n_sum;
    logic                r_stream,  n_stream;
    logic                r_armed,   n_armed;
    logic [31:0]         r_count,   n_count;
    logic [31:0]         r_timeout;
    logic [7:0]          r_store [PAYLOAD_BYTES];

    logic                res_valid;
    logic                store_we;
    logic [31:0]         count_inc;
    t_result             res;

    function automatic logic [15:0] sum_update(input logic [15:0] s, input logic [7:0] b);
        logic [15:0] t;
        t = (s + {s[13:0], 2'b00}) + {8'h00, b};
        t = (t + {t[13:0], 2'b00}) + {8'h00, b};
        return t ^ {8'h00, t[15:8]};
    endfunction

    assign count_inc = r_count + 32'd1;

    always_comb begin
        n_phase   = r_phase;
        n_cmd     = r_cmd;
        n_idx     = r_idx;
        n_sum     = r_sum;
        n_stream  = r_stream;
        n_armed   = r_armed;
        n_count   = r_count;
        store_we  = 1'b0;
        res_valid = 1'b0;
        res       = '0;
        res.event_res = EV_ACK;

        if (i_item.mode) begin
            if (r_armed) begin
                n_count = count_inc;
                if (count_inc >= r_timeout) begin
                    n_armed       = 1'b0;
                    n_stream      = 1'b0;
                    res_valid     = 1'b1;
                    res.event_res = EV_TIMEOUT;
                end
            end
        end else begin
            case (r_phase)
                PH_HUNT: begin
                    if (i_item.rx_byte == FRAME_SOF) begin
                        n_phase = PH_CMD;
                    end
                end
                PH_CMD: begin
                    n_cmd       = i_item.rx_byte;
                    n_phase     = PH_HUNT;
                    res.command = i_item.rx_byte;
                    case (i_item.rx_byte)
                        CMD_CONNECT: begin
                            res_valid     = 1'b1;
                            res.event_res = EV_CONNECT;
                        end
                        CMD_PING: begin
                            n_armed     = 1'b1;
                            n_count     = '0;
                            res_valid   = 1'b1;
                            res.success = 1'b1;
                        end
                        CMD_START: begin
                            n_stream    = 1'b1;
                            n_armed     = 1'b1;
                            n_count     = '0;
                            res_valid   = 1'b1;
                            res.success = 1'b1;
                        end
                        CMD_STOP: begin
                            n_stream    = 1'b0;
                            n_armed     = 1'b0;
                            n_count     = '0;
                            res_valid   = 1'b1;
                            res.success = 1'b1;
                        end
                        CMD_GAINS_MAIN, CMD_GAINS_YAW: begin
                            n_phase = PH_DATA;
                            n_idx   = '0;
                            n_sum   = '0;
                        end
                        default: begin
                        end
                    endcase
                end
                PH_DATA: begin
                    store_we = (r_idx < IDX_W'(PAYLOAD_BYTES));
                    n_sum    = sum_update(r_sum, i_item.rx_byte);
                    n_idx    = r_idx + IDX_W'(1);
                    if (n_idx >= IDX_W'(PAYLOAD_BYTES)) begin
                        n_phase = PH_SUM;
                    end
                end
                PH_SUM: begin
                    n_phase         = PH_HUNT;
                    res_valid       = 1'b1;
                    res.command     = r_cmd;
                    res.success     = (r_sum[7:0] == i_item.rx_byte);
                    res.gains_valid = 1'b1;
                    res.gain_word_p = {r_store[3], r_store[2], r_store[1], r_store[0]};
                    res.gain_word_i = {r_store[7], r_store[6], r_store[5], r_store[4]};
                    res.gain_word_d = {r_store[11], r_store[10], r_store[9], r_store[8]};
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
        res.streaming_active = n_stream;
    end

    // The item stays in the input register until its result has a place to go.
    assign o_take   = i_valid && (!res_valid || i_out_ready);
    assign o_push   = i_valid && res_valid && i_out_ready;
    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_cmd    <= '0;
            r_idx    <= '0;
            r_sum    <= '0;
            r_stream <= 1'b0;
            r_armed  <= 1'b0;
            r_count  <= '0;
        end else if (o_take) begin
            r_phase  <= n_phase;
            r_cmd    <= n_cmd;
            r_idx    <= n_idx;
            r_sum    <= n_sum;
            r_stream <= n_stream;
            r_armed  <= n_armed;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_valid) begin
            r_timeout <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && store_we) begin
            r_store[r_idx] <= i_item.rx_byte;
        end
    end

endmodule

// ----- design/cfr_out_reg.sv -----
// ----------------------------------------------------------------------------
// cfr_out_reg
// Result register on the master side; holds a beat while the sink stalls.
// ----------------------------------------------------------------------------
module cfr_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  cfr_pkg::t_result i_result,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_ready,
    output cfr_pkg::t_result o_result
);
    import cfr_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_ready  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_result <= i_result;
        end
    end

endmodule

// ----- design/command_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// command_frame_receiver
// Command frame parser with set-gains checksum and a tick-driven watchdog.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one beat per received serial byte (s_axis_tuser = 0) or per
//   timer tick (s_axis_tuser = 1). Master channel: at most one result beat per
//   input beat; m_axis_tuser carries the event code (connect request,
//   acknowledge, watchdog timeout). Configuration channel: a beat on
//   i_cfg_valid writes the 32-bit watchdog timeout in ticks; it is always
//   ready and should only be written while the block is idle.
//   Path: an accepted beat is held in the input register, is processed by
//   the combinational parser and watchdog logic while it sits there, and its
//   result is registered in the output register before it is shown on the
//   master side.
//   Throughput: one beat per cycle while no result beat is stalled; the parser
//   update (checksum step and 32-bit watchdog add and compare) is combinational.
//   Reset: i_rst_n is synchronous and active low; it empties both registers,
//   returns the parser to hunting for a start byte, clears the streaming flag,
//   disarms the watchdog and loads a timeout of 10000 ticks.
//   Stall: a result beat is held until m_axis_tready; meanwhile one more input
//   beat is taken, and beats that produce no result keep flowing.
// ----------------------------------------------------------------------------
module command_frame_receiver (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
    input  logic         s_axis_tuser,   // [0] mode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [7:0] command, [8] success, [9] gains_valid, [41:10] gain_word_p,
    // [73:42] gain_word_i, [105:74] gain_word_d, [106] streaming_active,
    // [111:107] zero
    output logic [cfr_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser,   // [1:0] event_res
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [31:0]  i_cfg_data     // timeout_ticks
);
    import cfr_pkg::*;

    t_item   in_item;
    t_item   reg_item;
    logic    reg_valid;
    logic    core_take;
    logic    core_push;
    logic    out_ready;
    t_result core_result;
    t_result out_result;

    assign in_item.mode    = s_axis_tuser;
    assign in_item.rx_byte = s_axis_tdata;
    assign o_cfg_ready     = 1'b1;

    cfr_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_valid (reg_valid),
        .o_item  (reg_item),
        .i_take  (core_take)
    );

    cfr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (reg_valid),
        .i_item      (reg_item),
        .o_take      (core_take),
        .i_out_ready (out_ready),
        .o_push      (core_push),
        .o_result    (core_result)
    );

    cfr_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (core_push),
        .i_result (core_result),
        .o_ready  (out_ready),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (out_result)
    );

    assign m_axis_tuser = out_result.event_res;
    assign m_axis_tdata = {5'b00000,
                           out_result.streaming_active,
                           out_result.gain_word_d,
                           out_result.gain_word_i,
                           out_result.gain_word_p,
                           out_result.gains_valid,
                           out_result.success,
                           out_result.command};

endmodule

// ----- design/cfr_checker.sv -----
// ----------------------------------------------------------------------------
// cfr_checker
// Port-level checks for the command frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module cfr_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [cfr_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);
    import cfr_pkg::*;

    // A result beat never appears in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat right after reset");

    // A stalled result beat stays valid.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    // A timeout clears streaming and carries no command or gains.
    a_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == EV_TIMEOUT) |->
            !m_axis_tdata[106] && (m_axis_tdata[9:0] == 10'd0))
        else $error("malformed timeout beat");

    // Gains are flagged only on an acknowledge, and only for a set-gains command.
    a_gains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[9] |->
            (m_axis_tuser == EV_ACK) &&
            ((m_axis_tdata[7:0] == CMD_GAINS_MAIN) || (m_axis_tdata[7:0] == CMD_GAINS_YAW)))
        else $error("gains flagged on a non set-gains beat");

endmodule

bind command_frame_receiver cfr_checker u_cfr_checker (.*);
